// File: rtl/bis_pkg.sv
package bis_pkg;

    localparam int PIXEL_W = 32;
    localparam int LANES = 4;
    localparam int LANE_W = 8;
    localparam int COORD_W = 8;
    localparam int POS_W = 32;
    localparam int FRAC_W = 8;
    localparam int SIZE_CFG_W = 9;
    localparam int SCALE_W = 24;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE = 8'd3;

    localparam logic [SIZE_CFG_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Output queue and the credits that keep it from overflowing.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int CREDIT_W = 4;

    typedef struct packed {
        logic [CREDIT_W-1:0] count;
        logic                full;
    } t_fifo_stat;

endpackage

// File: rtl/bis_in_if.sv
interface bis_in_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [bis_pkg::COORD_W-1:0]      coord_x;
    logic [bis_pkg::COORD_W-1:0]      coord_y;
    logic [bis_pkg::PIXEL_W-1:0]      pixel_in;

    modport source(output valid, action, coord_x, coord_y, pixel_in, input ready);
    modport sink(input valid, action, coord_x, coord_y, pixel_in, output ready);
endinterface

// File: rtl/bis_out_if.sv
interface bis_out_if;
    logic                             valid;
    logic                             ready;
    logic [bis_pkg::PIXEL_W-1:0]      pixel_out;

    modport source(output valid, pixel_out, input ready);
    modport sink(input valid, pixel_out, output ready);
endinterface

// File: rtl/bilinear_image_scaler.sv
// Bilinear image scaler.
// Input channel i_in carries beats of two kinds. A load beat (action 0) writes
// pixel_in to the stored picture at (coord_x, coord_y) and gives no output. A
// sample beat (action 1) gives one interpolated pixel on o_out for destination
// point (coord_x, coord_y). Output beats leave in the order of the sample beats.
// The picture sits in four one-port-read banks split by column and row parity,
// so all four neighbours are read in the same cycle, and one beat is taken per
// clock while credits remain. A sample beat passes stages A to D, the blend
// registers and the output buffer before it is offered on o_out; a load takes
// effect for every beat accepted after it.
// Results queue in an eight-entry output buffer; a credit counter drops
// i_in.ready when the buffer and the pipeline together hold eight samples, so a
// stalled receiver holds off the sender without losing a beat.
// Configuration writes on i_cfg_* are taken at any edge with i_cfg_we high and
// should only be made while no sample is in flight.
// Reset restores the sizes to 256 and both scales to 1.0; the picture is not
// cleared, and sampling a pixel that was never loaded gives an undefined value.
module bilinear_image_scaler #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bis_in_if.sink                           i_in,
    bis_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bis_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WSZ = $clog2(MAX_WIDTH + 1);
    localparam int HSZ = $clog2(MAX_HEIGHT + 1);
    localparam int HALF_W = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // Configuration registers.
    logic [bis_pkg::SIZE_CFG_W-1:0] r_src_w;
    logic [bis_pkg::SIZE_CFG_W-1:0] r_src_h;
    logic [bis_pkg::SCALE_W-1:0]    r_x_scale;
    logic [bis_pkg::SCALE_W-1:0]    r_y_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= bis_pkg::SIZE_RESET;
            r_src_h <= bis_pkg::SIZE_RESET;
            r_x_scale <= bis_pkg::SCALE_RESET;
            r_y_scale <= bis_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bis_pkg::CFG_SOURCE_WIDTH: r_src_w <= i_cfg_data[bis_pkg::SIZE_CFG_W-1:0];
                bis_pkg::CFG_SOURCE_HEIGHT: r_src_h <= i_cfg_data[bis_pkg::SIZE_CFG_W-1:0];
                bis_pkg::CFG_X_SCALE: r_x_scale <= i_cfg_data;
                bis_pkg::CFG_Y_SCALE: r_y_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective sizes: zero counts as one, anything past the store is the store.
    logic [WSZ-1:0] size_w;
    logic [HSZ-1:0] size_h;

    always_comb begin
        if (r_src_w == '0) begin
            size_w = WSZ'(1);
        end else if (32'(r_src_w) > MAX_WIDTH) begin
            size_w = WSZ'(MAX_WIDTH);
        end else begin
            size_w = WSZ'(32'(r_src_w));
        end
        if (r_src_h == '0) begin
            size_h = HSZ'(1);
        end else if (32'(r_src_h) > MAX_HEIGHT) begin
            size_h = HSZ'(MAX_HEIGHT);
        end else begin
            size_h = HSZ'(32'(r_src_h));
        end
    end

    // Credits and input acceptance.
    logic                           r_credit_valid_unused;
    logic [bis_pkg::CREDIT_W-1:0]   r_credit;
    logic [bis_pkg::CREDIT_W-1:0]   n_credit;
    logic                           in_acc;
    logic                           take;
    logic                           give;
    bis_pkg::t_fifo_stat            fifo_stat;
    logic                           fifo_valid;

    assign i_in.ready = (r_credit != '0);
    assign in_acc = i_in.valid && i_in.ready;
    assign take = in_acc && (i_in.action == bis_pkg::ACT_SAMPLE);
    assign give = fifo_valid && o_out.ready;

    always_comb begin
        n_credit = r_credit;
        if (take && !give) begin
            n_credit = r_credit - 1'b1;
        end else if (give && !take) begin
            n_credit = r_credit + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= bis_pkg::CREDIT_W'(bis_pkg::FIFO_DEPTH);
            r_credit_valid_unused <= 1'b0;
        end else begin
            r_credit <= n_credit;
            r_credit_valid_unused <= fifo_stat.full;
        end
    end

    // Stage A: accepted beat.
    logic                           r_a_valid;
    logic                           r_a_action;
    logic [bis_pkg::COORD_W-1:0]    r_a_cx;
    logic [bis_pkg::COORD_W-1:0]    r_a_cy;
    logic [bis_pkg::PIXEL_W-1:0]    r_a_pix;

    // Stage B: scaled positions.
    logic                           r_b_valid;
    logic                           r_b_action;
    logic                           r_b_ld_ok;
    logic [XW-1:0]                  r_b_lx;
    logic [YW-1:0]                  r_b_ly;
    logic [bis_pkg::POS_W-1:0]      r_b_posx;
    logic [bis_pkg::POS_W-1:0]      r_b_posy;
    logic [bis_pkg::PIXEL_W-1:0]    r_b_pix;

    // Stage C: neighbour indices; memory accesses are issued from here.
    logic                           r_c_valid;
    logic                           r_c_action;
    logic                           r_c_ld_ok;
    logic [XW-1:0]                  r_c_x0;
    logic [XW-1:0]                  r_c_x1;
    logic [YW-1:0]                  r_c_y0;
    logic [YW-1:0]                  r_c_y1;
    logic [bis_pkg::FRAC_W-1:0]     r_c_fx;
    logic [bis_pkg::FRAC_W-1:0]     r_c_fy;
    logic [bis_pkg::PIXEL_W-1:0]    r_c_pix;

    // Stage D: memory data arrives alongside these.
    logic                           r_d_valid;
    logic [1:0]                     r_d_xb;
    logic [1:0]                     r_d_yb;
    logic [bis_pkg::FRAC_W-1:0]     r_d_fx;
    logic [bis_pkg::FRAC_W-1:0]     r_d_fy;

    logic [XW-1:0]                  loc_x0;
    logic [XW-1:0]                  loc_x1;
    logic [YW-1:0]                  loc_y0;
    logic [YW-1:0]                  loc_y1;
    logic [bis_pkg::FRAC_W-1:0]     loc_fx;
    logic [bis_pkg::FRAC_W-1:0]     loc_fy;

    bis_locate #(.IW(XW), .SZW(WSZ)) u_loc_x (
        .i_pos  (r_b_posx),
        .i_size (size_w),
        .o_lo   (loc_x0),
        .o_hi   (loc_x1),
        .o_frac (loc_fx)
    );

    bis_locate #(.IW(YW), .SZW(HSZ)) u_loc_y (
        .i_pos  (r_b_posy),
        .i_size (size_h),
        .o_lo   (loc_y0),
        .o_hi   (loc_y1),
        .o_frac (loc_fy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= in_acc;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid && (r_c_action == bis_pkg::ACT_SAMPLE);
        end
        r_a_action <= i_in.action;
        r_a_cx <= i_in.coord_x;
        r_a_cy <= i_in.coord_y;
        r_a_pix <= i_in.pixel_in;

        r_b_action <= r_a_action;
        r_b_ld_ok <= (32'(r_a_cx) < MAX_WIDTH) && (32'(r_a_cy) < MAX_HEIGHT);
        r_b_lx <= XW'(32'(r_a_cx));
        r_b_ly <= YW'(32'(r_a_cy));
        r_b_posx <= bis_pkg::POS_W'(32'(r_a_cx) * 32'(r_x_scale));
        r_b_posy <= bis_pkg::POS_W'(32'(r_a_cy) * 32'(r_y_scale));
        r_b_pix <= r_a_pix;

        r_c_action <= r_b_action;
        r_c_ld_ok <= r_b_ld_ok;
        r_c_x0 <= (r_b_action == bis_pkg::ACT_SAMPLE) ? loc_x0 : r_b_lx;
        r_c_y0 <= (r_b_action == bis_pkg::ACT_SAMPLE) ? loc_y0 : r_b_ly;
        r_c_x1 <= loc_x1;
        r_c_y1 <= loc_y1;
        r_c_fx <= loc_fx;
        r_c_fy <= loc_fy;
        r_c_pix <= r_b_pix;

        r_d_xb <= {r_c_x1[0], r_c_x0[0]};
        r_d_yb <= {r_c_y1[0], r_c_y0[0]};
        r_d_fx <= r_c_fx;
        r_d_fy <= r_c_fy;
    end

    // Four banks by (row parity, column parity). Each beat passes stage C alone,
    // so a load always writes before any later sample reads: no forwarding.
    logic [bis_pkg::PIXEL_W-1:0] bank_rdata [4];
    logic [AW-1:0]               wr_addr;

    assign wr_addr = AW'(32'(r_c_y0 >> 1) * HALF_H * 0 + 32'(r_c_y0 >> 1) * HALF_W
                         + 32'(r_c_x0 >> 1));

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [XW-1:0] xs;
        logic [YW-1:0] ys;
        logic [AW-1:0] rd_addr;
        logic          we;

        assign xs = (r_c_x0[0] == 1'(b % 2)) ? r_c_x0 : r_c_x1;
        assign ys = (r_c_y0[0] == 1'(b / 2)) ? r_c_y0 : r_c_y1;
        assign rd_addr = AW'(32'(ys >> 1) * HALF_W + 32'(xs >> 1));
        assign we = r_c_valid && (r_c_action == bis_pkg::ACT_LOAD) && r_c_ld_ok
                    && (r_c_x0[0] == 1'(b % 2)) && (r_c_y0[0] == 1'(b / 2));

        bis_ram #(.WIDTH(bis_pkg::PIXEL_W), .DEPTH(BANK_DEPTH)) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (wr_addr),
            .i_wdata (r_c_pix),
            .i_raddr (rd_addr),
            .o_rdata (bank_rdata[b])
        );
    end

    logic                        blend_valid;
    logic [bis_pkg::PIXEL_W-1:0] blend_pixel;

    bis_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_valid),
        .i_p00   (bank_rdata[{r_d_yb[0], r_d_xb[0]}]),
        .i_p10   (bank_rdata[{r_d_yb[0], r_d_xb[1]}]),
        .i_p01   (bank_rdata[{r_d_yb[1], r_d_xb[0]}]),
        .i_p11   (bank_rdata[{r_d_yb[1], r_d_xb[1]}]),
        .i_fx    (r_d_fx),
        .i_fy    (r_d_fy),
        .o_valid (blend_valid),
        .o_pixel (blend_pixel)
    );

    bis_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (blend_valid),
        .i_data  (blend_pixel),
        .i_pop   (o_out.ready),
        .o_valid (fifo_valid),
        .o_data  (o_out.pixel_out),
        .o_stat  (fifo_stat)
    );

    assign o_out.valid = fifo_valid;

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_credit) <= bis_pkg::FIFO_DEPTH)
        else $error("credit count above buffer depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blend_valid |-> !fifo_stat.full || o_out.ready)
        else $error("output buffer written while full");

    a_sample_reaches_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.action == bis_pkg::ACT_SAMPLE) |-> ##4 r_d_valid)
        else $error("sample beat lost before memory read");

    a_credit_covers_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_credit) + 32'(fifo_stat.count) <= bis_pkg::FIFO_DEPTH)
        else $error("buffered results exceed granted credits");

    // Checks that the debug register holding the buffer-full flag agrees with the flag it sampled.
    a_full_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit_valid_unused |-> $past(fifo_stat.full))
        else $error("full flag history mismatch");
endmodule

// File: rtl/bis_ram.sv
module bis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/bis_locate.sv
module bis_locate #(
    parameter int IW = 8,
    parameter int SZW = 9
) (
    input  logic [bis_pkg::POS_W-1:0]  i_pos,
    input  logic [SZW-1:0]             i_size,
    output logic [IW-1:0]              o_lo,
    output logic [IW-1:0]              o_hi,
    output logic [bis_pkg::FRAC_W-1:0] o_frac
);
    logic [15:0]   ip;
    logic [IW-1:0] lo;

    always_comb begin
        ip = i_pos[31:16];
        // The integer part saturates at the last column or row.
        if (32'(ip) >= 32'(i_size)) begin
            lo = IW'(32'(i_size) - 32'd1);
        end else begin
            lo = IW'(32'(ip));
        end
        o_lo = lo;
        if (32'(lo) + 32'd1 >= 32'(i_size)) begin
            o_hi = lo;
        end else begin
            o_hi = IW'(32'(lo) + 32'd1);
        end
        o_frac = i_pos[15:8];
    end
endmodule

// File: rtl/bis_blend.sv
module bis_blend (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [bis_pkg::PIXEL_W-1:0] i_p00,
    input  logic [bis_pkg::PIXEL_W-1:0] i_p10,
    input  logic [bis_pkg::PIXEL_W-1:0] i_p01,
    input  logic [bis_pkg::PIXEL_W-1:0] i_p11,
    input  logic [bis_pkg::FRAC_W-1:0] i_fx,
    input  logic [bis_pkg::FRAC_W-1:0] i_fy,
    output logic                       o_valid,
    output logic [bis_pkg::PIXEL_W-1:0] o_pixel
);
    logic                        r_e_valid;
    logic [15:0]                 r_top [bis_pkg::LANES];
    logic [15:0]                 r_bot [bis_pkg::LANES];
    logic [bis_pkg::FRAC_W-1:0]  r_fy;
    logic                        r_f_valid;
    logic [bis_pkg::PIXEL_W-1:0] r_pixel;
    logic [15:0]                 n_top [bis_pkg::LANES];
    logic [15:0]                 n_bot [bis_pkg::LANES];
    logic [bis_pkg::PIXEL_W-1:0] n_pixel;
    logic [8:0]                  wx;
    logic [8:0]                  wy;
    logic [24:0]                 sum;

    always_comb begin
        wx = 9'd256 - {1'b0, i_fx};
        for (int l = 0; l < bis_pkg::LANES; l++) begin
            n_top[l] = 16'(17'(wx) * 17'(i_p00[l*8 +: 8]) + 17'(i_fx) * 17'(i_p10[l*8 +: 8]));
            n_bot[l] = 16'(17'(wx) * 17'(i_p01[l*8 +: 8]) + 17'(i_fx) * 17'(i_p11[l*8 +: 8]));
        end
    end

    always_comb begin
        wy = 9'd256 - {1'b0, r_fy};
        sum = '0;
        n_pixel = '0;
        for (int l = 0; l < bis_pkg::LANES; l++) begin
            sum = 25'(wy) * 25'(r_top[l]) + 25'(r_fy) * 25'(r_bot[l]);
            n_pixel[l*8 +: 8] = sum[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else begin
            r_e_valid <= i_valid;
            r_f_valid <= r_e_valid;
        end
        r_top <= n_top;
        r_bot <= n_bot;
        r_fy <= i_fy;
        r_pixel <= n_pixel;
    end

    assign o_valid = r_f_valid;
    assign o_pixel = r_pixel;
endmodule

// File: rtl/bis_fifo.sv
module bis_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [bis_pkg::PIXEL_W-1:0] i_data,
    input  logic                        i_pop,
    output logic                        o_valid,
    output logic [bis_pkg::PIXEL_W-1:0] o_data,
    output bis_pkg::t_fifo_stat         o_stat
);
    logic [bis_pkg::PIXEL_W-1:0]    r_mem [bis_pkg::FIFO_DEPTH];
    logic [bis_pkg::FIFO_PTR_W-1:0] r_wr;
    logic [bis_pkg::FIFO_PTR_W-1:0] r_rd;
    logic [bis_pkg::CREDIT_W-1:0]   r_count;
    logic                           pop;

    function automatic logic [bis_pkg::CREDIT_W-1:0] CREDIT_ONE(input logic b);
        return {{(bis_pkg::CREDIT_W-1){1'b0}}, b};
    endfunction

    assign pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + CREDIT_ONE(i_push) - CREDIT_ONE(pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data = r_mem[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.full = (32'(r_count) == bis_pkg::FIFO_DEPTH);
endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    typedef struct {
        logic                          action;
        logic [bis_pkg::COORD_W-1:0]   cx;
        logic [bis_pkg::COORD_W-1:0]   cy;
        logic [bis_pkg::PIXEL_W-1:0]   pix;
    } t_pixel_beat;

    localparam int CYCLE_LIMIT = 400000;
    localparam int STORE_W = 256;
    localparam int ITEM_TARGET = 1200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [bis_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    bis_in_if inb();
    bis_out_if outb();

    bilinear_image_scaler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (inb),
        .o_out      (outb),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_pixel_beat pending_beats[$];
    logic [bis_pkg::PIXEL_W-1:0] expected_pixels[$];

    // Predictor state: its own copy of the picture and the registers.
    logic [bis_pkg::PIXEL_W-1:0] picture[0:STORE_W*STORE_W-1];
    logic [bis_pkg::SIZE_CFG_W-1:0] cur_width = bis_pkg::SIZE_RESET;
    logic [bis_pkg::SIZE_CFG_W-1:0] cur_height = bis_pkg::SIZE_RESET;
    logic [bis_pkg::SCALE_W-1:0] cur_xscale = bis_pkg::SCALE_RESET;
    logic [bis_pkg::SCALE_W-1:0] cur_yscale = bis_pkg::SCALE_RESET;

    // Which entries the generator has queued a load for.
    bit loaded[0:STORE_W*STORE_W-1];

    int fails = 0;
    int cycles = 0;
    int queued = 0;
    int snd_idle = 0;
    int rcv_idle = 0;
    bit took = 0;
    t_pixel_beat drv_beat;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        fails++;
    endtask

    function automatic int eff_size(input logic [bis_pkg::SIZE_CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > STORE_W) return STORE_W;
        return int'(v);
    endfunction

    task automatic split_pos(input logic [bis_pkg::COORD_W-1:0] c,
                             input logic [bis_pkg::SCALE_W-1:0] s,
                             input int size, output int lo, output int hi,
                             output logic [31:0] fr);
        logic [bis_pkg::POS_W-1:0] pos;
        int ip;
        pos = bis_pkg::POS_W'(c) * bis_pkg::POS_W'(s);
        ip = int'(pos >> 16);
        if (ip >= size) ip = size - 1;
        lo = ip;
        hi = (ip + 1 >= size) ? ip : ip + 1;
        fr = 32'(pos[15:8]);
    endtask

    task automatic interpolate(input t_pixel_beat b);
        int x0, x1, y0, y1;
        logic [31:0] fx, fy, top, bot, v;
        logic [bis_pkg::PIXEL_W-1:0] p00, p10, p01, p11, res;
        if (b.action == bis_pkg::ACT_LOAD) begin
            picture[int'(b.cy) * STORE_W + int'(b.cx)] = b.pix;
            return;
        end
        split_pos(b.cx, cur_xscale, eff_size(cur_width), x0, x1, fx);
        split_pos(b.cy, cur_yscale, eff_size(cur_height), y0, y1, fy);
        p00 = picture[y0 * STORE_W + x0];
        p10 = picture[y0 * STORE_W + x1];
        p01 = picture[y1 * STORE_W + x0];
        p11 = picture[y1 * STORE_W + x1];
        res = '0;
        for (int l = 0; l < bis_pkg::LANES; l++) begin
            top = (256 - fx) * 32'(p00[l*bis_pkg::LANE_W +: bis_pkg::LANE_W])
                  + fx * 32'(p10[l*bis_pkg::LANE_W +: bis_pkg::LANE_W]);
            bot = (256 - fx) * 32'(p01[l*bis_pkg::LANE_W +: bis_pkg::LANE_W])
                  + fx * 32'(p11[l*bis_pkg::LANE_W +: bis_pkg::LANE_W]);
            v = ((256 - fy) * top + fy * bot) >> 16;
            res[l*bis_pkg::LANE_W +: bis_pkg::LANE_W] = v[7:0];
        end
        expected_pixels.push_back(res);
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
        if (i_rst_n && inb.valid && inb.ready) begin
            interpolate('{inb.action, inb.coord_x, inb.coord_y, inb.pixel_in});
            took = 1;
        end
        if (i_rst_n && outb.valid && outb.ready) begin
            if (expected_pixels.size() == 0)
                report($sformatf("unexpected output beat %h", outb.pixel_out));
            else if (outb.pixel_out !== expected_pixels[0])
                report($sformatf("pixel_out %h, expected %h", outb.pixel_out,
                                 expected_pixels[0]));
            if (expected_pixels.size() != 0) void'(expected_pixels.pop_front());
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            inb.valid <= 1'b0;
        end else if (!inb.valid || took) begin
            took = 0;
            if (pending_beats.size() > 0 && $urandom_range(99) >= snd_idle) begin
                drv_beat = pending_beats.pop_front();
                inb.valid <= 1'b1;
                inb.action <= drv_beat.action;
                inb.coord_x <= drv_beat.cx;
                inb.coord_y <= drv_beat.cy;
                inb.pixel_in <= drv_beat.pix;
            end else begin
                inb.valid <= 1'b0;
            end
        end
        outb.ready <= ($urandom_range(99) >= rcv_idle);
    end

    task automatic queue_beat(input logic act, input int x, input int y,
                              input logic [bis_pkg::PIXEL_W-1:0] p);
        pending_beats.push_back('{act, bis_pkg::COORD_W'(x), bis_pkg::COORD_W'(y), p});
        queued++;
        if (act == bis_pkg::ACT_LOAD) loaded[y * STORE_W + x] = 1;
    endtask

    // Loads every entry of the active area for which no load has been queued yet.
    task automatic fill_area(input int w, input int h);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                if (!loaded[y * STORE_W + x])
                    queue_beat(bis_pkg::ACT_LOAD, x, y, $urandom);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (!(pending_beats.size() == 0 && !inb.valid && expected_pixels.size() == 0));
        // A trailing load beat may still be in the pipeline.
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [bis_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bis_pkg::CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        case (idx)
            bis_pkg::CFG_SOURCE_WIDTH: cur_width = d[bis_pkg::SIZE_CFG_W-1:0];
            bis_pkg::CFG_SOURCE_HEIGHT: cur_height = d[bis_pkg::SIZE_CFG_W-1:0];
            bis_pkg::CFG_X_SCALE: cur_xscale = d;
            bis_pkg::CFG_Y_SCALE: cur_yscale = d;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [bis_pkg::SCALE_W-1:0] pick_scale(input int size);
        int dest;
        case ($urandom_range(5))
            0: return bis_pkg::SCALE_RESET;
            1: return 24'd1;
            2: return 24'hFFFFFF;
            3: return bis_pkg::SCALE_W'($urandom_range(24'hFFFFFF, 1));
            4: return bis_pkg::SCALE_W'($urandom_range(24'h30000, 24'h4000));
            default: begin
                dest = $urandom_range(256, 1);
                return bis_pkg::SCALE_W'(((32'(size) << 16) / dest) | 1);
            end
        endcase
    endfunction

    task automatic run_phase(input logic [bis_pkg::SIZE_CFG_W-1:0] w,
                             input logic [bis_pkg::SIZE_CFG_W-1:0] h,
                             input logic [bis_pkg::SCALE_W-1:0] xs,
                             input logic [bis_pkg::SCALE_W-1:0] ys,
                             input int n);
        int ew, eh;
        wait_idle();
        snd_idle = 0;
        rcv_idle = 0;
        case ($urandom_range(3))
            1: snd_idle = 52;
            2: rcv_idle = 52;
            3: begin snd_idle = 16; rcv_idle = 16; end
            default: ;
        endcase
        write_reg(bis_pkg::CFG_SOURCE_WIDTH, {15'($urandom_range(32767)), w});
        write_reg(bis_pkg::CFG_SOURCE_HEIGHT, {15'($urandom_range(32767)), h});
        write_reg(bis_pkg::CFG_X_SCALE, xs);
        write_reg(bis_pkg::CFG_Y_SCALE, ys);
        // An index past the last register must leave all of them alone.
        write_reg(bis_pkg::CFG_IDX_W'($urandom_range(255, 4)),
                  bis_pkg::CFG_DATA_W'($urandom));
        ew = eff_size(w);
        eh = eff_size(h);
        fill_area(ew, eh);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 25) begin
                if ($urandom_range(3) == 0)
                    queue_beat(bis_pkg::ACT_LOAD, $urandom_range(255), $urandom_range(255),
                               $urandom);
                else
                    queue_beat(bis_pkg::ACT_LOAD, $urandom_range(ew - 1),
                               $urandom_range(eh - 1), $urandom);
            end else begin
                queue_beat(bis_pkg::ACT_SAMPLE, $urandom_range(255), $urandom_range(255),
                           $urandom);
            end
        end
    endtask

    initial begin
        logic [bis_pkg::SIZE_CFG_W-1:0] w, h;
        inb.valid = 1'b0;
        inb.action = bis_pkg::ACT_LOAD;
        inb.coord_x = '0;
        inb.coord_y = '0;
        inb.pixel_in = '0;
        outb.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset registers: unit scale, so origin lands exactly on one pixel.
        queue_beat(bis_pkg::ACT_LOAD, 0, 0, 32'hFFFFFFFF);
        queue_beat(bis_pkg::ACT_LOAD, 1, 0, 32'h00000000);
        queue_beat(bis_pkg::ACT_LOAD, 0, 1, 32'h00FF00FF);
        queue_beat(bis_pkg::ACT_LOAD, 1, 1, 32'hFF00FF00);
        queue_beat(bis_pkg::ACT_SAMPLE, 0, 0, 32'hFFFFFFFF);
        wait_idle();

        // Two by two picture: half steps, edge clamps, smallest and largest scales.
        write_reg(bis_pkg::CFG_SOURCE_WIDTH, 24'd2);
        write_reg(bis_pkg::CFG_SOURCE_HEIGHT, 24'd2);
        write_reg(bis_pkg::CFG_X_SCALE, 24'h008000);
        write_reg(bis_pkg::CFG_Y_SCALE, 24'h008000);
        queue_beat(bis_pkg::ACT_SAMPLE, 1, 1, '0);
        queue_beat(bis_pkg::ACT_SAMPLE, 255, 255, '0);
        queue_beat(bis_pkg::ACT_SAMPLE, 2, 1, '0);
        queue_beat(bis_pkg::ACT_SAMPLE, 0, 255, '0);
        wait_idle();
        write_reg(bis_pkg::CFG_X_SCALE, 24'hFFFFFF);
        write_reg(bis_pkg::CFG_Y_SCALE, 24'd1);
        queue_beat(bis_pkg::ACT_SAMPLE, 255, 255, '0);
        queue_beat(bis_pkg::ACT_SAMPLE, 1, 128, '0);
        queue_beat(bis_pkg::ACT_SAMPLE, 0, 0, '0);
        wait_idle();
        // A size of zero acts as one, and a size past the store, such as 511 below, as the full store.
        write_reg(bis_pkg::CFG_SOURCE_WIDTH, 24'd0);
        write_reg(bis_pkg::CFG_SOURCE_HEIGHT, 24'd0);
        queue_beat(bis_pkg::ACT_SAMPLE, 200, 17, '0);
        queue_beat(bis_pkg::ACT_SAMPLE, 255, 0, '0);

        run_phase(9'd511, 9'd1, 24'h00FF00, 24'h010000, 20);
        run_phase(9'd1, 9'd256, 24'd1, 24'h00FFFF, 20);
        run_phase(9'd256, 9'd1, 24'hFFFFFF, 24'hFFFFFF, 20);

        while (queued < ITEM_TARGET) begin
            if ($urandom_range(9) == 0) begin
                w = 9'($urandom_range(511));
                h = 9'($urandom_range(2));
            end else begin
                w = 9'($urandom_range(16, 1));
                h = 9'($urandom_range(16, 1));
            end
            run_phase(w, h, pick_scale(eff_size(w)), pick_scale(eff_size(h)), 40);
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/bis_pkg.sv
rtl/bis_in_if.sv
rtl/bis_out_if.sv
rtl/bis_ram.sv
rtl/bis_locate.sv
rtl/bis_blend.sv
rtl/bis_fifo.sv
rtl/bilinear_image_scaler.sv
verif/tb.sv
